// ----- hw/rtl/tmme_pkg.sv -----
package tmme_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int ID_BITS      = 8;
  localparam int PAYLOAD_BITS = 32;
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_POST  = 2'd0,
    REQ_TAKE  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_WAKE  = 2'd3
  } req_t;

  localparam logic [1:0] MSG_WAKE    = 2'd0;
  localparam logic [1:0] MSG_WAITING = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ID_BITS-1:0]      sender;
    logic [ID_BITS-1:0]      receiver;
    logic [1:0]              mtype;
    logic [PAYLOAD_BITS-1:0] payload;
  } msg_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic post;
    logic shift;
    logic keep;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/tmme_cell.sv -----
module tmme_cell
  import tmme_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic      below_vld,
  input  logic      above_vld,
  input  msg_t      above_msg,
  input  msg_t      head_msg,
  input  msg_t      new_msg,
  output logic      vld,
  output msg_t      msg
);

  logic vld_r, vld_nxt;
  msg_t msg_r, msg_nxt;

  // On a shift the chain moves down by one; the last occupied cell takes the
  // head message back when it is kept, so the order is preserved.
  always_comb begin
    vld_nxt = vld_r;
    msg_nxt = msg_r;
    if (ctl.shift) begin
      if (above_vld) begin
        vld_nxt = 1'b1;
        msg_nxt = above_msg;
      end else if (vld_r) begin
        vld_nxt = ctl.keep;
        msg_nxt = head_msg;
      end
    end else if (ctl.post && !vld_r && below_vld) begin
      vld_nxt = 1'b1;
      msg_nxt = new_msg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    msg_r <= msg_nxt;
  end

  assign vld = vld_r;
  assign msg = msg_r;

endmodule

// ----- hw/rtl/tagged_mailbox_match_extract_core.sv -----
// Tagged mailbox with match-and-extract.
// A request is accepted on a rising edge where start is high and busy is low.
// in_req_type selects a post, a take, a waiting-for query or a wake-up consume.
// Results appear on the out_ ports for exactly one cycle, marked by out_valid;
// out_last marks the final result of a request. The receiver cannot stall.
// A post answers in the cycle after acceptance and the block is ready again at
// once. A take, query or consume on an empty store also answers in the cycle after acceptance.
// Otherwise the request circulates every stored message once through the head
// of the chain of cells, one message per cycle, then passes through ST_DONE;
// busy stays high through ST_SCAN and ST_DONE and the next request can follow after that.
// Take results stream out during the circulation, each one in the cycle after the
// next match is found; the final one comes with the closing result.
// A synchronous active-low reset empties the store; no clearing pass is needed.
module tagged_mailbox_match_extract_core
  import tmme_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_req_type,
  input  logic [ID_BITS-1:0]      in_sender_id,
  input  logic [ID_BITS-1:0]      in_receiver_id,
  input  logic [1:0]              in_msg_type,
  input  logic [PAYLOAD_BITS-1:0] in_payload,
  output logic                    out_valid,
  output logic                    out_found,
  output logic [ID_BITS-1:0]      out_sender,
  output logic [ID_BITS-1:0]      out_receiver,
  output logic [1:0]              out_type,
  output logic [PAYLOAD_BITS-1:0] out_payload,
  output logic                    out_last,
  output logic                    out_overflow
);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  req_t req_r, req_nxt;
  logic [ID_BITS-1:0] snd_r, snd_nxt, rcv_r, rcv_nxt;
  logic [1:0] typ_r, typ_nxt;
  logic pend_v_r, pend_v_nxt, hit_r, hit_nxt;
  msg_t pend_r, pend_nxt;

  logic out_valid_r, out_valid_nxt, out_found_r, out_found_nxt;
  logic out_last_r, out_last_nxt, out_ovf_r, out_ovf_nxt;
  msg_t out_msg_r, out_msg_nxt;

  cell_ctl_t ctl;
  logic vld [QUEUE_DEPTH];
  msg_t msg [QUEUE_DEPTH];
  msg_t new_msg;
  logic accept, full, head_match, keep;
  logic [1:0] want_type;

  assign accept = start && (state_r == ST_IDLE);
  assign full   = vld[QUEUE_DEPTH-1];
  assign new_msg = '{sender: in_sender_id, receiver: in_receiver_id,
                     mtype: in_msg_type, payload: in_payload};

  // The chain: cell 0 is the head, the oldest message.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic below_v, above_v;
    msg_t above_m;
    if (i == 0) begin : g_lo
      assign below_v = 1'b1;
    end else begin : g_lo
      assign below_v = vld[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_hi
      assign above_v = 1'b0;
      assign above_m = msg[i];
    end else begin : g_hi
      assign above_v = vld[i+1];
      assign above_m = msg[i+1];
    end
    tmme_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .below_vld (below_v),
      .above_vld (above_v),
      .above_msg (above_m),
      .head_msg  (msg[0]),
      .new_msg   (new_msg),
      .vld       (vld[i]),
      .msg       (msg[i])
    );
  end

  // Match test on the message at the head of the chain.
  always_comb begin
    case (req_r)
      REQ_TAKE: want_type = typ_r;
      REQ_QUERY: want_type = MSG_WAITING;
      default: want_type = MSG_WAKE;
    endcase
  end

  assign head_match = vld[0] && (msg[0].receiver == rcv_r) &&
                      (msg[0].mtype == want_type) &&
                      ((req_r != REQ_QUERY) || (msg[0].sender == snd_r));
  assign keep = !(head_match && (req_r != REQ_QUERY));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (req_t'(in_req_type) != REQ_POST) && (fill_r != '0)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control and results.
  always_comb begin
    ctl           = '0;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    req_nxt       = req_r;
    snd_nxt       = snd_r;
    rcv_nxt       = rcv_r;
    typ_nxt       = typ_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    hit_nxt       = hit_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = 1'b0;
    out_last_nxt  = 1'b0;
    out_ovf_nxt   = 1'b0;
    out_msg_nxt   = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (req_t'(in_req_type) == REQ_POST) begin
            ctl.post      = 1'b1;
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b1;
            out_ovf_nxt   = full;
            if (!full) begin
              fill_nxt = fill_r + CNT_W'(1);
            end
          end else if (fill_r == '0) begin
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b1;
          end else begin
            req_nxt    = req_t'(in_req_type);
            snd_nxt    = in_sender_id;
            rcv_nxt    = in_receiver_id;
            typ_nxt    = in_msg_type;
            cnt_nxt    = fill_r;
            pend_v_nxt = 1'b0;
            hit_nxt    = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        ctl.shift = 1'b1;
        ctl.keep  = keep;
        cnt_nxt   = cnt_r - CNT_W'(1);
        if (!keep) begin
          fill_nxt = fill_r - CNT_W'(1);
        end
        if (head_match) begin
          hit_nxt = 1'b1;
          if (req_r == REQ_TAKE) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_found_nxt = 1'b1;
              out_msg_nxt   = pend_r;
            end
            pend_v_nxt = 1'b1;
            pend_nxt   = msg[0];
          end
        end
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        out_found_nxt = hit_r;
        if ((req_r == REQ_TAKE) && pend_v_r) begin
          out_msg_nxt = pend_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    snd_r       <= snd_nxt;
    rcv_r       <= rcv_nxt;
    typ_r       <= typ_nxt;
    pend_r      <= pend_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_msg_r   <= out_msg_nxt;
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_sender   = out_msg_r.sender;
  assign out_receiver = out_msg_r.receiver;
  assign out_type     = out_msg_r.mtype;
  assign out_payload  = out_msg_r.payload;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

  // When idle the head cell is occupied exactly when the fill count is non-zero.
  a_head_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (vld[0] == (fill_r != '0)))
    else $error("head occupancy disagrees with fill count");

  // When idle the last cell is occupied exactly when the store is full.
  a_tail_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (full == (fill_r == CNT_W'(QUEUE_DEPTH))))
    else $error("tail occupancy disagrees with fill count");

  // An accepted post on a store that is not full grows the fill by one.
  a_post_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req_type == REQ_POST) && !full) |=>
      (fill_r == $past(fill_r) + CNT_W'(1)))
    else $error("post did not grow the store");

  // A request that reaches ST_DONE yields a registered closing result with out_valid and out_last.
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> (out_valid && out_last))
    else $error("closing result missing");

endmodule
